// ===== rtl/core/slcfp_pkg.sv =====
// Shared types and constants for the sync/length/checksum frame parser.
// No dependencies; imported by every module of the block.
package slcfp_pkg;

  localparam int MAX_PAYLOAD_DEF = 16;

  localparam int BYTE_W = 8;
  localparam int CNT_W  = 5;   // payload counters, bounded by max_length
  localparam int STAT_W = 2;
  localparam int IDX_W  = 4;
  localparam int CFG_IDX_W = 2;
  localparam int OUT_TDATA_W = 32;
  localparam int OUT_TUSER_W = 3;

  localparam logic [BYTE_W-1:0] SYNC_RESET = 8'hEA;
  localparam logic [CNT_W-1:0]  MAXLEN_RESET = 5'd16;
  localparam logic [BYTE_W-1:0] SEED_RESET = 8'hFF;

  localparam logic [CFG_IDX_W-1:0] CFG_SYNC   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAXLEN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SEED   = 2'd2;

  localparam logic [STAT_W-1:0] STATUS_OK      = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_LEN_ERR = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_CHK_ERR = 2'd2;

  typedef enum logic [2:0] {
    ST_HUNT,
    ST_CMD,
    ST_LEN,
    ST_DATA,
    ST_CHECK,
    ST_EMIT
  } state_t;

  // What the output register loads this cycle.
  typedef enum logic [2:0] {
    RES_NONE,
    RES_LEN_ERR,
    RES_CHK_ERR,
    RES_EMPTY,
    RES_DATA
  } res_t;

  typedef struct packed {
    logic start;       // sync seen: seed the check
    logic take_cmd;
    logic take_len;    // update check with length byte
    logic hold_len;    // length accepted: latch it, clear count
    logic take_data;
    res_t res;
  } ctrl_cmd_t;

  typedef struct packed {
    logic sync_hit;
    logic len_bad;
    logic len_zero;    // current byte is zero
    logic held_zero;   // latched length is zero
    logic data_done;
    logic check_ok;
    logic emit_last;
    logic out_free;
  } dp_stat_t;

endpackage

// ===== rtl/core/slcfp_ctrl.sv =====
// Frame parser controller: phase state machine and command decode.
// Depends on slcfp_pkg.
module slcfp_ctrl import slcfp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  input  dp_stat_t  stat,
  output ctrl_cmd_t cmd
);

  state_t state_r, state_nxt;
  logic   acc;

  assign in_tready = (state_r != ST_EMIT) && stat.out_free;
  assign acc = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_HUNT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_HUNT: if (acc && stat.sync_hit) state_nxt = ST_CMD;
      ST_CMD:  if (acc) state_nxt = ST_LEN;
      ST_LEN: begin
        if (acc) begin
          priority if (stat.len_bad) state_nxt = ST_HUNT;
          else if (stat.len_zero)    state_nxt = ST_CHECK;
          else                       state_nxt = ST_DATA;
        end
      end
      ST_DATA: if (acc && stat.data_done) state_nxt = ST_CHECK;
      ST_CHECK: begin
        if (acc) begin
          if (stat.check_ok && !stat.held_zero) state_nxt = ST_EMIT;
          else                                  state_nxt = ST_HUNT;
        end
      end
      ST_EMIT: if (stat.out_free && stat.emit_last) state_nxt = ST_HUNT;
      default: state_nxt = ST_HUNT;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.res = RES_NONE;
    unique case (state_r)
      ST_HUNT: cmd.start = acc && stat.sync_hit;
      ST_CMD:  cmd.take_cmd = acc;
      ST_LEN: begin
        cmd.take_len = acc;
        cmd.hold_len = acc && !stat.len_bad;
        if (acc && stat.len_bad) cmd.res = RES_LEN_ERR;
      end
      ST_DATA: cmd.take_data = acc;
      ST_CHECK: begin
        if (acc) begin
          priority if (!stat.check_ok) cmd.res = RES_CHK_ERR;
          else if (stat.held_zero)     cmd.res = RES_EMPTY;
          else                         cmd.res = RES_NONE;
        end
      end
      ST_EMIT: if (stat.out_free) cmd.res = RES_DATA;
      default: cmd.res = RES_NONE;
    endcase
  end

endmodule

// ===== rtl/core/slcfp_dpath.sv =====
// Frame parser datapath: config registers, running check, payload store,
// payload readout and the output register. Depends on slcfp_pkg.
module slcfp_dpath import slcfp_pkg::*; #(
  parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_valid,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [BYTE_W-1:0]      cfg_data,
  input  logic [BYTE_W-1:0]      rx_byte,
  input  ctrl_cmd_t              cmd,
  output dp_stat_t               stat,
  input  logic                   out_tready,
  output logic                   out_tvalid,
  output logic [STAT_W-1:0]      out_status,
  output logic [BYTE_W-1:0]      out_command,
  output logic [BYTE_W-1:0]      out_length,
  output logic [IDX_W-1:0]       out_index,
  output logic [BYTE_W-1:0]      out_data,
  output logic                   out_has_data,
  output logic                   out_last
);

  localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam logic [BYTE_W:0] MP_CAP = (BYTE_W+1)'(MAX_PAYLOAD);

  logic [BYTE_W-1:0] sync_r, seed_r;
  logic [CNT_W-1:0]  maxlen_r;

  logic [BYTE_W-1:0] chk_r, chk_nxt;
  logic [BYTE_W-1:0] cmd_r;
  logic [CNT_W-1:0]  len_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [CNT_W-1:0]  eidx_r, eidx_nxt;

  logic [BYTE_W-1:0] store_mem [MAX_PAYLOAD];
  logic [BYTE_W-1:0] rd_data_r;
  logic [AW-1:0]     rd_addr;

  logic              ovalid_r;
  logic [STAT_W-1:0] ostat_r, ostat_nxt;
  logic [BYTE_W-1:0] ocmd_r;
  logic [BYTE_W-1:0] olen_r, olen_nxt;
  logic [BYTE_W-1:0] odata_r, odata_nxt;
  logic [IDX_W-1:0]  oidx_r, oidx_nxt;
  logic              ohas_r, ohas_nxt;
  logic              olast_r, olast_nxt;

  logic [BYTE_W:0]   limit;
  logic [CNT_W:0]    cnt_inc, eidx_inc;
  logic              cnt_in_store;

  // config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_r   <= SYNC_RESET;
      maxlen_r <= MAXLEN_RESET;
      seed_r   <= SEED_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_SYNC:   sync_r   <= cfg_data;
        CFG_MAXLEN: maxlen_r <= cfg_data[CNT_W-1:0];
        CFG_SEED:   seed_r   <= cfg_data;
        default:    ;
      endcase
    end
  end

  assign limit = ((BYTE_W+1)'(maxlen_r) < MP_CAP) ? (BYTE_W+1)'(maxlen_r) : MP_CAP;
  assign cnt_inc  = {1'b0, cnt_r} + 1'b1;
  assign eidx_inc = {1'b0, eidx_r} + 1'b1;
  assign cnt_in_store = ((BYTE_W+1)'(cnt_r) < MP_CAP);

  assign stat.sync_hit  = (rx_byte == sync_r);
  assign stat.len_bad   = ({1'b0, rx_byte} > limit);
  assign stat.len_zero  = (rx_byte == '0);
  assign stat.held_zero = (len_r == '0);
  assign stat.data_done = (cnt_inc >= {1'b0, len_r});
  assign stat.check_ok  = (rx_byte == chk_r);
  assign stat.emit_last = (eidx_inc == {1'b0, len_r});
  assign stat.out_free  = !ovalid_r || out_tready;

  always_comb begin
    chk_nxt = chk_r;
    if (cmd.start) chk_nxt = seed_r - rx_byte;
    else if (cmd.take_cmd || cmd.take_len || cmd.take_data) chk_nxt = chk_r - rx_byte;
  end

  // frame registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chk_r <= '0;
      cmd_r <= '0;
      len_r <= '0;
      cnt_r <= '0;
    end else begin
      chk_r <= chk_nxt;
      if (cmd.take_cmd) cmd_r <= rx_byte;
      if (cmd.hold_len) begin
        len_r <= rx_byte[CNT_W-1:0];  // bounded by limit, fits
        cnt_r <= '0;
      end else if (cmd.take_data) begin
        cnt_r <= cnt_inc[CNT_W-1:0];
      end
    end
  end

  // payload readout index; back to zero after the final result
  always_comb begin
    eidx_nxt = eidx_r;
    if (cmd.res == RES_DATA) eidx_nxt = stat.emit_last ? '0 : eidx_inc[CNT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) eidx_r <= '0;
    else        eidx_r <= eidx_nxt;
  end

  // read one ahead so a result can leave every cycle while the output register is free
  assign rd_addr = AW'(eidx_nxt);

  always_ff @(posedge clk) begin
    if (cmd.take_data && cnt_in_store) store_mem[AW'(cnt_r)] <= rx_byte;
    rd_data_r <= store_mem[rd_addr];
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovalid_r <= 1'b0;
    end else if (cmd.res != RES_NONE) begin
      ovalid_r <= 1'b1;
    end else if (out_tready) begin
      ovalid_r <= 1'b0;
    end
  end

  always_comb begin
    ostat_nxt = STATUS_OK;
    olen_nxt  = {{(BYTE_W-CNT_W){1'b0}}, len_r};
    oidx_nxt  = '0;
    odata_nxt = '0;
    ohas_nxt  = 1'b0;
    olast_nxt = 1'b1;
    unique case (cmd.res)
      RES_LEN_ERR: begin
        ostat_nxt = STATUS_LEN_ERR;
        olen_nxt  = rx_byte;
      end
      RES_CHK_ERR: ostat_nxt = STATUS_CHK_ERR;
      RES_DATA: begin
        oidx_nxt  = eidx_r[IDX_W-1:0];
        odata_nxt = rd_data_r;
        ohas_nxt  = 1'b1;
        olast_nxt = stat.emit_last;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.res != RES_NONE) begin
      ocmd_r  <= cmd_r;
      ostat_r <= ostat_nxt;
      olen_r  <= olen_nxt;
      oidx_r  <= oidx_nxt;
      odata_r <= odata_nxt;
      ohas_r  <= ohas_nxt;
      olast_r <= olast_nxt;
    end
  end

  assign out_tvalid   = ovalid_r;
  assign out_status   = ostat_r;
  assign out_command  = ocmd_r;
  assign out_length   = olen_r;
  assign out_index    = oidx_r;
  assign out_data     = odata_r;
  assign out_has_data = ohas_r;
  assign out_last     = olast_r;

endmodule

// ===== rtl/core/sync_length_checksum_frame_parser_top.sv =====
// Sync/length/checksum frame parser, top level. Uses slcfp_pkg, slcfp_ctrl, slcfp_dpath.
// Throughput: one input byte per cycle while the output register is free or drains
//   that cycle; input is held off while a payload streams out.
// Latency: error and empty-frame results are valid the cycle after the byte's request;
//   payload results pass the emit state and output register, one per cycle unless stalled.
// Reset: rst_n synchronous, active low; hunting for sync, config at defaults, output empty.
module sync_length_checksum_frame_parser_top import slcfp_pkg::*; #(
  parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // input stream: tdata[7:0] rx_byte
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [BYTE_W-1:0]      in_tdata,
  // result stream: tdata[7:0] command, [15:8] length, [19:16] byte_index,
  //   [27:20] data_byte, [31:28] zero
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // tuser[1:0] status, [2] has_data
  output logic [OUT_TUSER_W-1:0] out_tuser,
  output logic                   out_tlast,
  // register writes: 0 sync_value, 1 max_length, 2 check_seed
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [BYTE_W-1:0]      cfg_data
);

  ctrl_cmd_t         cmd;
  dp_stat_t          stat;
  logic [STAT_W-1:0] o_status;
  logic [BYTE_W-1:0] o_command, o_length, o_data;
  logic [IDX_W-1:0]  o_index;
  logic              o_has;

  // registers always writable; the user must make writes only while idle; not enforced here
  assign cfg_ready = 1'b1;

  slcfp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  slcfp_dpath #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_dpath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_valid    (cfg_valid && cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .rx_byte      (in_tdata),
    .cmd          (cmd),
    .stat         (stat),
    .out_tready   (out_tready),
    .out_tvalid   (out_tvalid),
    .out_status   (o_status),
    .out_command  (o_command),
    .out_length   (o_length),
    .out_index    (o_index),
    .out_data     (o_data),
    .out_has_data (o_has),
    .out_last     (out_tlast)
  );

  assign out_tdata = {4'b0000, o_data, o_index, o_length, o_command};
  assign out_tuser = {o_has, o_status};

  // a result is only loaded into a free output register
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.res != RES_NONE) |-> stat.out_free)
    else $error("result loaded over a pending request");

  // no byte is taken while the payload is streaming out
  a_emit_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.res == RES_DATA) |-> !in_tready)
    else $error("input accepted during payload readout");

  // every loaded result is valid on the next cycle
  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.res != RES_NONE) |=> out_tvalid)
    else $error("loaded result not presented");

endmodule
